// ===== hw/rtl/lvpp_pkg.sv =====
// Shared types and constants for the linked vector packet parser.
package lvpp_pkg;

	localparam int unsigned WORD_W = 16;
	localparam int unsigned IDX_W  = 14;

	localparam logic [WORD_W-1:0] CODE_PLAIN = 16'd6;
	localparam logic [WORD_W-1:0] CODE_VALUE = 16'd9;
	localparam logic [WORD_W-1:0] HDR_PLAIN  = 16'd4;
	localparam logic [WORD_W-1:0] HDR_VALUE  = 16'd6;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_TERM  = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_BADCODE = 2'd1;
	localparam logic [1:0] STATUS_TRUNC   = 2'd2;

	typedef enum logic [6:0] {
		PH_CODE = 7'b0000001,
		PH_LEN  = 7'b0000010,
		PH_VAL  = 7'b0000100,
		PH_SI   = 7'b0001000,
		PH_SJ   = 7'b0010000,
		PH_EI   = 7'b0100000,
		PH_EJ   = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [WORD_W-1:0] pkt_code;
		logic [WORD_W-1:0] vector_value;
		logic              has_value;
		logic [WORD_W-1:0] coord_i;
		logic [WORD_W-1:0] coord_j;
		logic [IDX_W-1:0]  vector_index;
		logic [1:0]        status;
		logic              last;
	} result_t;

endpackage

// ===== hw/rtl/linked_vector_packet_parser.sv =====
// Linked vector packet parser: byte stream in, one point record per result.
//
// Input stream: s_axis_tdata carries one byte of a big-endian packet stream,
// s_axis_tuser marks the end of the source (the byte is then ignored). The
// parser reads a 16-bit packet code and block length, a value word for code
// 9, a start point and the end points, and emits one result per point. The
// last result of a packet has tlast set and carries its status. An end of
// source inside a packet gives one termination result with truncated status.
// Throughput: one byte per cycle unless the result register stalls; an
// accepted byte drives the state and result registers combinationally.
// Latency: a result is valid in the cycle after the transfer of the byte that
// completes its J coordinate (or of the end-of-source marker).
// Reset: the parser waits for a packet code, no result is pending.
// Stall: the result register holds while m_axis_tready is low; a new byte is
// still taken when that register is empty or being drained in the same cycle.
module linked_vector_packet_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,  // [0] stream_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] pkt_code, [31:16] vector_value, [47:32] coord_i,
	// [63:48] coord_j, [77:64] vector_index, [79:78] status
	output logic [79:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser,  // [1:0] kind, [2] has_value
	output logic        m_axis_tlast
);
	import lvpp_pkg::*;

	phase_t              phase_q, phase_d;
	logic [7:0]          high_q, high_d;
	logic                half_q, half_d;
	logic [WORD_W-1:0]   code_q, code_d;
	logic [WORD_W-1:0]   value_q, value_d;
	logic [WORD_W-1:0]   pend_i_q, pend_i_d;
	logic [IDX_W-1:0]    vleft_q, vleft_d;
	logic [IDX_W-1:0]    vcnt_q, vcnt_d;

	logic                out_valid_q;
	result_t             out_q;

	logic                acc;
	logic                emit;
	logic                go_idle;
	result_t             res;
	logic [WORD_W-1:0]   w;
	logic [WORD_W-1:0]   need;
	logic [WORD_W-1:0]   diff;
	logic [IDX_W-1:0]    vleft_dec;
	logic                hv_now;
	logic [1:0]          fin_status;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign acc           = s_axis_tvalid && s_axis_tready;

	assign w          = {high_q, s_axis_tdata};
	assign need       = (code_q == CODE_VALUE) ? HDR_VALUE : HDR_PLAIN;
	assign diff       = w - need;
	assign vleft_dec  = vleft_q - IDX_W'(1);
	assign hv_now     = (code_q == CODE_VALUE) && (phase_q == PH_SI || phase_q == PH_SJ ||
		phase_q == PH_EI || phase_q == PH_EJ);
	assign fin_status = (code_q == CODE_PLAIN || code_q == CODE_VALUE) ? STATUS_OK
		: STATUS_BADCODE;

	always_comb begin
		phase_d  = phase_q;
		high_d   = high_q;
		half_d   = half_q;
		code_d   = code_q;
		value_d  = value_q;
		pend_i_d = pend_i_q;
		vleft_d  = vleft_q;
		vcnt_d   = vcnt_q;
		emit     = 1'b0;
		go_idle  = 1'b0;

		res.kind         = KIND_START;
		res.pkt_code     = code_q;
		res.vector_value = hv_now ? value_q : '0;
		res.has_value    = hv_now;
		res.coord_i      = pend_i_q;
		res.coord_j      = w;
		res.vector_index = '0;
		res.status       = STATUS_OK;
		res.last         = 1'b0;

		if (s_axis_tuser[0]) begin
			if (!(phase_q == PH_CODE && !half_q)) begin
				emit         = 1'b1;
				res.kind     = KIND_TERM;
				res.coord_i  = '0;
				res.coord_j  = '0;
				res.status   = STATUS_TRUNC;
				res.last     = 1'b1;
				go_idle      = 1'b1;
			end
		end else if (!half_q) begin
			high_d = s_axis_tdata;
			half_d = 1'b1;
		end else begin
			half_d = 1'b0;
			case (phase_q)
				PH_CODE: begin
					code_d  = w;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					vleft_d = (w >= need) ? diff[WORD_W-1:2] : '0;
					vcnt_d  = '0;
					phase_d = (code_q == CODE_VALUE) ? PH_VAL : PH_SI;
				end
				PH_VAL: begin
					value_d = w;
					phase_d = PH_SI;
				end
				PH_SI: begin
					pend_i_d = w;
					phase_d  = PH_SJ;
				end
				PH_SJ: begin
					emit = 1'b1;
					if (vleft_q == '0) begin
						res.status = fin_status;
						res.last   = 1'b1;
						go_idle    = 1'b1;
					end else begin
						phase_d = PH_EI;
					end
				end
				PH_EI: begin
					pend_i_d = w;
					phase_d  = PH_EJ;
				end
				PH_EJ: begin
					emit             = 1'b1;
					res.kind         = KIND_END;
					res.vector_index = vcnt_q;
					vleft_d          = vleft_dec;
					if (vleft_dec == '0) begin
						res.status = fin_status;
						res.last   = 1'b1;
						go_idle    = 1'b1;
					end else begin
						vcnt_d  = vcnt_q + IDX_W'(1);
						phase_d = PH_EI;
					end
				end
				default: begin
					go_idle = 1'b1;
				end
			endcase
		end

		// back to the header for the next packet
		if (go_idle) begin
			phase_d  = PH_CODE;
			high_d   = '0;
			half_d   = 1'b0;
			code_d   = '0;
			value_d  = '0;
			pend_i_d = '0;
			vleft_d  = '0;
			vcnt_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_CODE;
			high_q   <= '0;
			half_q   <= 1'b0;
			code_q   <= '0;
			value_q  <= '0;
			pend_i_q <= '0;
			vleft_q  <= '0;
			vcnt_q   <= '0;
		end else if (acc) begin
			phase_q  <= phase_d;
			high_q   <= high_d;
			half_q   <= half_d;
			code_q   <= code_d;
			value_q  <= value_d;
			pend_i_q <= pend_i_d;
			vleft_q  <= vleft_d;
			vcnt_q   <= vcnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= acc && emit;
		end
	end

	// load only on a new result; a stalled result holds
	always_ff @(posedge clk) begin
		if (acc && emit) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.status, out_q.vector_index, out_q.coord_j, out_q.coord_i,
		out_q.vector_value, out_q.pkt_code};
	assign m_axis_tuser  = {out_q.has_value, out_q.kind};
	assign m_axis_tlast  = out_q.last;

	a_nonfinal_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> out_q.status == STATUS_OK && out_q.kind != KIND_TERM)
		else $error("non-final result with status or termination");

	a_term_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_q.kind == KIND_TERM |-> out_q.status == STATUS_TRUNC && out_q.last)
		else $error("termination result without truncated status");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc && emit && res.last |=> phase_q == PH_CODE && !half_q && code_q == '0)
		else $error("parser not idle after final result");

	a_value_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_q.has_value |-> out_q.pkt_code == CODE_VALUE)
		else $error("vector value flagged on a packet without value word");

endmodule
